/* src/gdad_pkg.sv */
// Package with shared constants, types and calendar functions for the date adder.
`timescale 1ns / 1ps
package gdad_pkg;

	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int YearW  = 14;
	localparam int CountW = 16;
	localparam int CycW   = 9;

	localparam logic [YearW-1:0]  YearMax   = {YearW{1'b1}};
	localparam logic [CountW-1:0] Cycle400  = CountW'(400);
	localparam logic [CycW-1:0]   CycLast   = CycW'(399);
	localparam logic [CycW-1:0]   Cent1     = CycW'(100);
	localparam logic [CycW-1:0]   Cent2     = CycW'(200);
	localparam logic [CycW-1:0]   Cent3     = CycW'(300);
	localparam logic [MonthW-1:0] MonJan    = MonthW'(1);
	localparam logic [MonthW-1:0] MonFeb    = MonthW'(2);
	localparam logic [MonthW-1:0] MonDec    = MonthW'(12);
	localparam logic [DayW-1:0]   DayFirst  = DayW'(1);

	// Result of the shared compare-subtract unit.
	typedef struct packed {
		logic              ge;
		logic [CountW-1:0] diff;
	} sub_res_t;

	// Leap test on the year's position within the 400-year cycle.
	function automatic logic is_leap(input logic [CycW-1:0] cyc);
		is_leap = (cyc[1:0] == 2'b00) && (cyc != Cent1) && (cyc != Cent2)
			&& (cyc != Cent3);
	endfunction

	function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
		input logic leap);
		logic [DayW-1:0] n;
		unique case (m)
			4'd2:                    n = leap ? DayW'(29) : DayW'(28);
			4'd4, 4'd6, 4'd9, 4'd11: n = DayW'(30);
			default:                 n = DayW'(31);
		endcase
		month_days = n;
	endfunction

endpackage

/* src/gdad_sub.sv */
// Shared compare-subtract unit used for cycle reduction and the month walk.
`timescale 1ns / 1ps
module gdad_sub (
	input  logic [gdad_pkg::CountW-1:0] a,
	input  logic [gdad_pkg::CountW-1:0] b,
	output gdad_pkg::sub_res_t          res
);

	logic [gdad_pkg::CountW:0] wide;

	assign wide     = {1'b0, a} - {1'b0, b};
	assign res.ge   = ~wide[gdad_pkg::CountW];
	assign res.diff = wide[gdad_pkg::CountW-1:0];

endmodule

/* src/gregorian_date_add_days.sv */
// Top level of the Gregorian date adder: sequencer, walk registers and output register.
`timescale 1ns / 1ps
// Usage
//   Input channel: month, day, year, day_count qualified by in_valid; a transfer
//   happens at a rising edge with in_valid high and in_stall low. in_stall is high
//   from the cycle after a transfer until the sequencer returns to idle.
//   Output channel: new_month, new_day, new_year qualified by out_valid; the
//   receiver holds out_stall high to hold the result, which then stays unchanged.
//   Out-of-range months and days are clamped before the walk starts.
// Sequence
//   One transfer passes through: reduction steps that place the year in the 400-year
//   leap cycle, a clamp step, then one step per month crossed plus one or two closing
//   steps (the last partial month, then loading the result). The month walk
//   dominates: 65535 days cross about 2153 months. The reduction and the month walk
//   run through the single compare-subtract unit, one step per cycle.
//   A new item can be taken while the previous result waits on out_stall; its
//   walk then holds at the end until the output register is free.
// Reset
//   arst_n low clears the sequencer to idle and drops out_valid; no clearing pass.
module gregorian_date_add_days (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gdad_pkg::MonthW-1:0]   month,
	input  logic [gdad_pkg::DayW-1:0]     day,
	input  logic [gdad_pkg::YearW-1:0]    year,
	input  logic [gdad_pkg::CountW-1:0]   day_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gdad_pkg::MonthW-1:0]   new_month,
	output logic [gdad_pkg::DayW-1:0]     new_day,
	output logic [gdad_pkg::YearW-1:0]    new_year
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CLAMP,
		ST_WALK
	} state_t;

	state_t                          state_q;
	logic [gdad_pkg::MonthW-1:0]     month_q;
	logic [gdad_pkg::DayW-1:0]       day_q;
	logic [gdad_pkg::YearW-1:0]      year_q;
	logic [gdad_pkg::CountW-1:0]     left_q;
	logic [gdad_pkg::YearW-1:0]      rem_q;
	logic                            out_valid_q;
	logic [gdad_pkg::MonthW-1:0]     new_month_q;
	logic [gdad_pkg::DayW-1:0]       new_day_q;
	logic [gdad_pkg::YearW-1:0]      new_year_q;

	logic                            in_xfer;
	logic                            out_free;
	logic                            out_load;
	logic                            leap;
	logic [gdad_pkg::DayW-1:0]       mlen;
	logic [gdad_pkg::DayW-1:0]       rest;
	logic [gdad_pkg::CountW-1:0]     sub_a;
	logic [gdad_pkg::CountW-1:0]     sub_b;
	gdad_pkg::sub_res_t              sub_res;
	logic [gdad_pkg::MonthW-1:0]     month_clamped;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign new_month = new_month_q;
	assign new_day   = new_day_q;
	assign new_year  = new_year_q;
	// Output register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	// Load the finished date once the walk is done and the register is free.
	assign out_load  = (state_q == ST_WALK) && (left_q == '0) && out_free;

	// Leap status and length of the current month.
	assign leap = gdad_pkg::is_leap(rem_q[gdad_pkg::CycW-1:0]);
	assign mlen = gdad_pkg::month_days(month_q, leap);
	assign rest = mlen - day_q;

	// Clamp month to 1..12 on entry.
	always_comb begin
		if (month == '0) begin
			month_clamped = gdad_pkg::MonJan;
		end else if (month > gdad_pkg::MonDec) begin
			month_clamped = gdad_pkg::MonDec;
		end else begin
			month_clamped = month;
		end
	end

	// Feed the shared unit: cycle reduction or the days up to the 1st of the next month.
	always_comb begin
		if (state_q == ST_REDUCE) begin
			sub_a = gdad_pkg::CountW'(rem_q);
			sub_b = gdad_pkg::Cycle400;
		end else begin
			sub_a = left_q;
			sub_b = gdad_pkg::CountW'(rest) + gdad_pkg::CountW'(1);
		end
	end

	gdad_sub u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a load; drop it once the receiver takes the result.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						month_q <= month_clamped;
						day_q   <= day;
						year_q  <= year;
						rem_q   <= year;
						left_q  <= day_count;
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					// Subtract 400 until the year sits inside one leap cycle.
					if (sub_res.ge) begin
						rem_q <= sub_res.diff[gdad_pkg::YearW-1:0];
					end else begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					// Clamp the day to 1..length of the starting month.
					if (day_q == '0) begin
						day_q <= gdad_pkg::DayFirst;
					end else if (day_q > mlen) begin
						day_q <= mlen;
					end
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (left_q == '0) begin
						// Hold here until the output register frees up.
						if (out_load) begin
							new_month_q <= month_q;
							new_day_q   <= day_q;
							new_year_q  <= year_q;
							state_q     <= ST_IDLE;
						end
					end else if (sub_res.ge) begin
						// Use up the month and advance to the 1st of the next.
						left_q <= sub_res.diff;
						day_q  <= gdad_pkg::DayFirst;
						if (month_q == gdad_pkg::MonDec) begin
							month_q <= gdad_pkg::MonJan;
							if (year_q == gdad_pkg::YearMax) begin
								year_q <= '0;
								rem_q  <= '0;
							end else begin
								year_q <= year_q + gdad_pkg::YearW'(1);
								if (rem_q[gdad_pkg::CycW-1:0] == gdad_pkg::CycLast) begin
									rem_q <= '0;
								end else begin
									rem_q <= rem_q + gdad_pkg::YearW'(1);
								end
							end
						end else begin
							month_q <= month_q + gdad_pkg::MonthW'(1);
						end
					end else begin
						// Remaining count fits inside this month.
						day_q  <= day_q + left_q[gdad_pkg::DayW-1:0];
						left_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A transfer always starts the leap-cycle reduction.
	a_start_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_REDUCE)
		else $error("transfer did not start reduction");

	// Month stays in range during the walk.
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> (month_q != '0) && (month_q <= gdad_pkg::MonDec))
		else $error("month out of range during walk");

	// Day never exceeds the month length during the walk.
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> (day_q != '0) && (day_q <= mlen))
		else $error("day out of range during walk");

	// Cycle position stays below 400 once reduction ends.
	a_cycle_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLAMP || state_q == ST_WALK) |->
			rem_q < gdad_pkg::YearW'(400))
		else $error("leap cycle position out of range");

	// A finished result is never overwritten while stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && left_q == '0 && out_valid_q && out_stall)
			|=> state_q == ST_WALK)
		else $error("result loaded over a stalled one");

endmodule
